### rtl/core/twdm_pkg.sv
// Shared types and constants of the two-wire debug master pin sequencer.
// Used by every module under rtl/core; depends on nothing.
package twdm_pkg;

    typedef enum logic [2:0] {
        CMD_IDLE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_DRIVE  = 3'd3,
        CMD_SAMPLE = 3'd4,
        CMD_WAKE   = 3'd5
    } t_cmd;

    localparam logic [2:0] REG_LOW_TICKS         = 3'd0;
    localparam logic [2:0] REG_HIGH_TICKS        = 3'd1;
    localparam logic [2:0] REG_SAMPLE_LOW_TICKS  = 3'd2;
    localparam logic [2:0] REG_SAMPLE_HIGH_TICKS = 3'd3;
    localparam logic [2:0] REG_START_HALF_TICKS  = 3'd4;
    localparam logic [2:0] REG_WAKEUP_CLOCKS     = 3'd5;

    localparam logic [7:0] RST_LOW_TICKS         = 8'd92;
    localparam logic [7:0] RST_HIGH_TICKS        = 8'd42;
    localparam logic [7:0] RST_SAMPLE_LOW_TICKS  = 8'd30;
    localparam logic [7:0] RST_SAMPLE_HIGH_TICKS = 8'd30;
    localparam logic [7:0] RST_START_HALF_TICKS  = 8'd16;
    localparam logic [7:0] RST_WAKEUP_CLOCKS     = 8'd100;

    typedef struct packed {
        logic       en;
        logic [2:0] index;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0] low_ticks;
        logic [7:0] high_ticks;
        logic [7:0] sample_low_ticks;
        logic [7:0] sample_high_ticks;
        logic [7:0] start_half_ticks;
        logic [7:0] wakeup_clocks;
    } t_cfg;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] send_bits;
        logic [5:0]  bit_count;
        logic        stop_after;
        logic        swdio_in;
    } t_item;

    typedef struct packed {
        logic clk;
        logic dio;
        logic oe;
    } t_pins;

    typedef struct packed {
        t_pins      pins;
        logic [7:0] ticks;
    } t_enter;

    typedef struct packed {
        logic        swclk;
        logic        swdio_out;
        logic        swdio_oe;
        logic        busy_res;
        logic        read_valid;
        logic [31:0] read_bits;
    } t_result;

endpackage

### rtl/core/two_wire_debug_master_phy_unit.sv
// Two-wire debug master pin sequencer, top level.
// Depends on twdm_pkg, twdm_front, twdm_back and twdm_outq.
//
// Each request on the input queue (push/full) is one timing tick of the SWCLK
// and SWDIO waveform; an idle tick may carry a command: start, stop, drive or
// sample a number of bits MSB first, or wakeup with an optional stop.
// Every request yields exactly one result on the output queue (empty/pop):
// the pin levels of that tick, the busy flag and, when a sample ends, the
// sampled bits.
// Timing registers are written over the cfg channel, which is always ready;
// they should only be written while no request is in flight.
// A request is registered in the input queue, and its result in the result
// queue. While that queue has room the sequencer takes one request per cycle,
// so a push and a pop per cycle are sustained; its tick update is the only loop.
// Both queues hold two entries. When pop stays low the result queue fills,
// the sequencer halts and the input queue raises full once it holds two requests.
// Synchronous reset empties both queues, loads the slow timing values and
// returns the pins to clock high, data high, driven.
module two_wire_debug_master_phy_unit
    import twdm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_send_bits,
    input  logic [5:0]  i_bit_count,
    input  logic        i_stop_after,
    input  logic        i_swdio_in,
    output logic        empty,
    input  logic        pop,
    output logic        o_swclk,
    output logic        o_swdio_out,
    output logic        o_swdio_oe,
    output logic        o_busy_res,
    output logic        o_read_valid,
    output logic [31:0] o_read_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg_wr w_cfg;
    logic    w_item_valid;
    t_item   w_item;
    logic    w_item_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res_in;
    t_result w_res_out;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.en    = i_cfg_valid && o_cfg_ready;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    twdm_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_send_bits  (i_send_bits),
        .i_bit_count  (i_bit_count),
        .i_stop_after (i_stop_after),
        .i_swdio_in   (i_swdio_in),
        .i_pop        (w_item_pop),
        .o_valid      (w_item_valid),
        .o_item       (w_item)
    );

    twdm_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_res        (w_res_in)
    );

    twdm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_res_out)
    );

    assign o_swclk      = w_res_out.swclk;
    assign o_swdio_out  = w_res_out.swdio_out;
    assign o_swdio_oe   = w_res_out.swdio_oe;
    assign o_busy_res   = w_res_out.busy_res;
    assign o_read_valid = w_res_out.read_valid;
    assign o_read_bits  = w_res_out.read_bits;

`ifndef SYNTHESIS
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_read_valid && o_busy_res))
        else $error("read_valid shown while a command is still busy");

    a_bits_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_read_valid) |-> (o_read_bits == 32'd0))
        else $error("read_bits nonzero without read_valid");

    a_sample_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_read_valid) |-> !o_swdio_oe)
        else $error("SWDIO driven on the tick a sample ends");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");
`endif

endmodule

### rtl/core/twdm_front.sv
// Front end: decodes each tick request, clamps its bit count and holds it in a
// two-entry queue for the sequencer. Depends on twdm_pkg.
module twdm_front
    import twdm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_send_bits,
    input  logic [5:0]  i_bit_count,
    input  logic        i_stop_after,
    input  logic        i_swdio_in,
    input  logic        i_pop,
    output logic        o_valid,
    output t_item       o_item
);

    t_item       w_item;
    t_item       r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        w_push, w_pop;

    always_comb begin
        unique case (i_opcode) inside
            CMD_START, CMD_STOP, CMD_DRIVE, CMD_SAMPLE, CMD_WAKE: w_item.cmd = t_cmd'(i_opcode);
            default: w_item.cmd = CMD_IDLE;
        endcase
        w_item.send_bits  = i_send_bits;
        if ({1'b0, i_bit_count} > 7'(DATA_WIDTH)) begin
            w_item.bit_count = 6'(DATA_WIDTH);
        end else begin
            w_item.bit_count = i_bit_count;
        end
        w_item.stop_after = i_stop_after;
        w_item.swdio_in   = i_swdio_in;
    end

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = push && !full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = 2'(r_count + {1'b0, w_push} - {1'b0, w_pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

### rtl/core/twdm_back.sv
// Back end: the pin sequencer that carries out one tick per request and holds
// the timing registers. Depends on twdm_pkg.
module twdm_back
    import twdm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int IDX_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    t_cfg                  r_cfg;
    t_cmd                  r_cmd, n_cmd;
    logic [1:0]            r_phase, n_phase;
    logic [7:0]            r_tick, n_tick;
    logic [5:0]            r_bits, n_bits;
    logic [DATA_WIDTH-1:0] r_shift, n_shift;
    logic [7:0]            r_pulses, n_pulses;
    logic                  r_stop, n_stop;
    t_pins                 r_pins, n_pins;

    logic                  w_step;
    logic                  e1_go, e2_go;
    t_cmd                  e1_cmd, e2_cmd;
    logic [1:0]            e1_ph, e2_ph;
    t_enter                e1, e2;
    t_pins                 w_shown;
    logic                  w_valid;
    logic [63:0]           w_wide;

    function automatic t_enter f_enter(t_cmd cmd, logic [1:0] ph, logic has_bits,
                                       logic dbit, t_pins pins, t_cfg cfg);
        t_enter     e;
        logic [7:0] len;
        e.pins = pins;
        unique case (cmd)
            CMD_START: begin
                e.pins.oe  = 1'b1;
                e.pins.clk = 1'b1;
                e.pins.dio = (ph == 2'd0);
                len = cfg.start_half_ticks;
            end
            CMD_STOP: begin
                e.pins.oe  = 1'b1;
                e.pins.clk = (ph != 2'd0);
                e.pins.dio = (ph == 2'd2);
                len = (ph == 2'd0) ? cfg.low_ticks : cfg.high_ticks;
            end
            CMD_DRIVE: begin
                e.pins.oe  = 1'b1;
                e.pins.clk = (ph != 2'd0);
                if (ph == 2'd0 && has_bits) begin
                    e.pins.dio = dbit;
                end
                len = (ph == 2'd0) ? cfg.low_ticks : cfg.high_ticks;
            end
            CMD_SAMPLE: begin
                e.pins.clk = (ph != 2'd0);
                len = (ph == 2'd0) ? cfg.sample_low_ticks : cfg.sample_high_ticks;
            end
            default: begin
                e.pins.clk = (ph != 2'd0);
                len = (ph == 2'd0) ? cfg.low_ticks : cfg.high_ticks;
            end
        endcase
        e.ticks = (len == 8'd0) ? 8'd1 : len;
        return e;
    endfunction

    assign w_step     = i_item_valid && !i_res_full;
    assign o_item_pop = w_step;
    assign o_res_push = w_step;

    always_comb begin
        n_cmd    = r_cmd;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_pulses = r_pulses;
        n_stop   = r_stop;
        n_pins   = r_pins;
        w_valid  = 1'b0;
        e1_go    = 1'b0;
        e1_cmd   = CMD_IDLE;
        e1_ph    = 2'd0;
        e2_go    = 1'b0;
        e2_cmd   = CMD_IDLE;
        e2_ph    = 2'd0;

        if (r_cmd == CMD_IDLE) begin
            unique case (i_item.cmd)
                CMD_START: begin
                    e1_go  = 1'b1;
                    e1_cmd = CMD_START;
                end
                CMD_STOP: begin
                    e1_go  = 1'b1;
                    e1_cmd = CMD_STOP;
                end
                CMD_DRIVE: begin
                    if (i_item.bit_count != 6'd0) begin
                        n_shift = DATA_WIDTH'(i_item.send_bits);
                        n_bits  = i_item.bit_count;
                        e1_go   = 1'b1;
                        e1_cmd  = CMD_DRIVE;
                    end
                end
                CMD_SAMPLE: begin
                    n_pins.oe  = 1'b0;
                    n_pins.dio = 1'b1;
                    n_shift    = '0;
                    if (i_item.bit_count == 6'd0) begin
                        w_valid = 1'b1;
                    end else begin
                        n_bits = i_item.bit_count;
                        e1_go  = 1'b1;
                        e1_cmd = CMD_SAMPLE;
                    end
                end
                CMD_WAKE: begin
                    n_pins   = '{clk: 1'b1, dio: 1'b1, oe: 1'b1};
                    n_stop   = i_item.stop_after;
                    n_pulses = r_cfg.wakeup_clocks;
                    if (r_cfg.wakeup_clocks != 8'd0) begin
                        e1_go  = 1'b1;
                        e1_cmd = CMD_WAKE;
                    end else if (i_item.stop_after) begin
                        e1_go  = 1'b1;
                        e1_cmd = CMD_STOP;
                    end
                end
                default: begin
                end
            endcase
        end

        e1 = f_enter(e1_cmd, e1_ph, (n_bits != 6'd0),
                     n_shift[IDX_W'(6'(n_bits - 6'd1))], n_pins, r_cfg);
        if (e1_go) begin
            n_cmd   = e1_cmd;
            n_phase = e1_ph;
            n_pins  = e1.pins;
            n_tick  = e1.ticks;
        end

        w_shown = n_pins;

        if (n_cmd != CMD_IDLE) begin
            if (n_tick != 8'd0) begin
                n_tick = 8'(n_tick - 8'd1);
            end
            if (n_tick == 8'd0) begin
                unique case (n_cmd)
                    CMD_START: begin
                        if (n_phase == 2'd0) begin
                            e2_go  = 1'b1;
                            e2_cmd = CMD_START;
                            e2_ph  = 2'd1;
                        end else begin
                            n_cmd = CMD_IDLE;
                        end
                    end
                    CMD_STOP: begin
                        if (n_phase < 2'd2) begin
                            e2_go  = 1'b1;
                            e2_cmd = CMD_STOP;
                            e2_ph  = 2'(n_phase + 2'd1);
                        end else begin
                            n_cmd = CMD_IDLE;
                        end
                    end
                    CMD_DRIVE: begin
                        if (n_phase == 2'd0) begin
                            e2_go  = 1'b1;
                            e2_cmd = CMD_DRIVE;
                            e2_ph  = 2'd1;
                        end else begin
                            if (n_bits != 6'd0) begin
                                n_bits = 6'(n_bits - 6'd1);
                            end
                            if (n_bits == 6'd0) begin
                                n_cmd = CMD_IDLE;
                            end else begin
                                e2_go  = 1'b1;
                                e2_cmd = CMD_DRIVE;
                            end
                        end
                    end
                    CMD_SAMPLE: begin
                        if (n_phase == 2'd0) begin
                            e2_go  = 1'b1;
                            e2_cmd = CMD_SAMPLE;
                            e2_ph  = 2'd1;
                        end else begin
                            n_shift = {n_shift[DATA_WIDTH-2:0], i_item.swdio_in};
                            if (n_bits != 6'd0) begin
                                n_bits = 6'(n_bits - 6'd1);
                            end
                            if (n_bits == 6'd0) begin
                                n_cmd   = CMD_IDLE;
                                w_valid = 1'b1;
                            end else begin
                                e2_go  = 1'b1;
                                e2_cmd = CMD_SAMPLE;
                            end
                        end
                    end
                    CMD_WAKE: begin
                        if (n_phase == 2'd0) begin
                            e2_go  = 1'b1;
                            e2_cmd = CMD_WAKE;
                            e2_ph  = 2'd1;
                        end else begin
                            if (n_pulses != 8'd0) begin
                                n_pulses = 8'(n_pulses - 8'd1);
                            end
                            if (n_pulses != 8'd0) begin
                                e2_go  = 1'b1;
                                e2_cmd = CMD_WAKE;
                            end else if (n_stop) begin
                                e2_go  = 1'b1;
                                e2_cmd = CMD_STOP;
                            end else begin
                                n_cmd = CMD_IDLE;
                            end
                        end
                    end
                    default: n_cmd = CMD_IDLE;
                endcase
            end
        end

        e2 = f_enter(e2_cmd, e2_ph, (n_bits != 6'd0),
                     n_shift[IDX_W'(6'(n_bits - 6'd1))], n_pins, r_cfg);
        if (e2_go) begin
            n_cmd   = e2_cmd;
            n_phase = e2_ph;
            n_pins  = e2.pins;
            n_tick  = e2.ticks;
        end

        w_wide = 64'(n_shift);
        o_res.swclk      = w_shown.clk;
        o_res.swdio_out  = w_shown.dio;
        o_res.swdio_oe   = w_shown.oe;
        o_res.busy_res   = (n_cmd != CMD_IDLE);
        o_res.read_valid = w_valid;
        o_res.read_bits  = w_valid ? w_wide[31:0] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_ticks         <= RST_LOW_TICKS;
            r_cfg.high_ticks        <= RST_HIGH_TICKS;
            r_cfg.sample_low_ticks  <= RST_SAMPLE_LOW_TICKS;
            r_cfg.sample_high_ticks <= RST_SAMPLE_HIGH_TICKS;
            r_cfg.start_half_ticks  <= RST_START_HALF_TICKS;
            r_cfg.wakeup_clocks     <= RST_WAKEUP_CLOCKS;
        end else if (i_cfg.en) begin
            unique case (i_cfg.index)
                REG_LOW_TICKS:         r_cfg.low_ticks         <= i_cfg.data;
                REG_HIGH_TICKS:        r_cfg.high_ticks        <= i_cfg.data;
                REG_SAMPLE_LOW_TICKS:  r_cfg.sample_low_ticks  <= i_cfg.data;
                REG_SAMPLE_HIGH_TICKS: r_cfg.sample_high_ticks <= i_cfg.data;
                REG_START_HALF_TICKS:  r_cfg.start_half_ticks  <= i_cfg.data;
                REG_WAKEUP_CLOCKS:     r_cfg.wakeup_clocks     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= CMD_IDLE;
            r_phase  <= 2'd0;
            r_tick   <= 8'd0;
            r_bits   <= 6'd0;
            r_shift  <= '0;
            r_pulses <= 8'd0;
            r_stop   <= 1'b0;
            r_pins   <= '{clk: 1'b1, dio: 1'b1, oe: 1'b1};
        end else if (w_step) begin
            r_cmd    <= n_cmd;
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_pulses <= n_pulses;
            r_stop   <= n_stop;
            r_pins   <= n_pins;
        end
    end

endmodule

### rtl/core/twdm_outq.sv
// Result queue: two entries of pin levels and read data between the
// sequencer and the consumer. Depends on twdm_pkg.
module twdm_outq
    import twdm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    empty,
    input  logic    pop,
    output t_result o_res
);

    t_result    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_push, w_pop;

    assign o_full = (r_count == 2'd2);
    assign empty  = (r_count == 2'd0);
    assign o_res  = r_mem[r_rd_ptr];
    assign w_push = i_push && !o_full;
    assign w_pop  = pop && !empty;

    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = 2'(r_count + {1'b0, w_push} - {1'b0, w_pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

### bench/tb_two_wire_debug_master_phy_unit.sv
// Self-checking testbench for the two-wire debug master pin sequencer.
// Depends on twdm_pkg and two_wire_debug_master_phy_unit. Directed ticks come first,
// then random ticks under several timings, checked by a tick predictor or fixed results.
module tb_two_wire_debug_master_phy_unit;
    import twdm_pkg::*;

    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;
    localparam logic [5:0] WORD_BITS = 6'd32;
    localparam int         SCRIPT_LEN = 20;

    localparam t_result IDLE_PINS = '{swclk: 1'b1, swdio_out: 1'b1, swdio_oe: 1'b1,
                                      busy_res: 1'b0, read_valid: 1'b0, read_bits: 32'h0};
    localparam t_result EMPTY_READ = '{swclk: 1'b1, swdio_out: 1'b1, swdio_oe: 1'b0,
                                       busy_res: 1'b0, read_valid: 1'b1, read_bits: 32'h0};
    localparam t_result NO_CHECK = '0;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] send;
        logic [5:0]  count;
        logic        stop_after;
        logic        din;
    } t_tick;

    typedef struct {
        logic [2:0]  opcode;
        logic [31:0] send;
        logic [5:0]  count;
        logic        stop_after;
        logic        hold;
        logic        typed;
        t_result     want;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_opcode = CMD_IDLE;
    logic [31:0] i_send_bits = '0;
    logic [5:0]  i_bit_count = '0;
    logic        i_stop_after = 1'b0;
    logic        i_swdio_in = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_swclk;
    logic        o_swdio_out;
    logic        o_swdio_oe;
    logic        o_busy_res;
    logic        o_read_valid;
    logic [31:0] o_read_bits;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    two_wire_debug_master_phy_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_send_bits (i_send_bits),
        .i_bit_count (i_bit_count),
        .i_stop_after(i_stop_after),
        .i_swdio_in  (i_swdio_in),
        .empty       (empty),
        .pop         (pop),
        .o_swclk     (o_swclk),
        .o_swdio_out (o_swdio_out),
        .o_swdio_oe  (o_swdio_oe),
        .o_busy_res  (o_busy_res),
        .o_read_valid(o_read_valid),
        .o_read_bits (o_read_bits),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #6000000;
        $display("** two_wire_debug_master_phy_unit: FAILED **");
        $finish;
    end

    t_cfg        tmg;
    t_cmd        seq_cmd;
    logic [2:0]  seq_phase;
    logic [7:0]  seq_ticks;
    logic [5:0]  seq_bits;
    logic [31:0] seq_word;
    logic [7:0]  seq_pulses;
    logic        seq_stop;
    t_pins       seq_pins;

    t_result     tick_results_due[$];
    int          faults = 0;
    int          pop_rest = 0;
    bit          quiet_end = 1'b0;
    t_script_row script [SCRIPT_LEN];

    function automatic void enter_phase(t_cmd c, logic [2:0] ph);
        logic [7:0] len;
        len = 8'd1;
        seq_cmd = c;
        seq_phase = ph;
        case (c)
            CMD_START: begin
                seq_pins.oe = 1'b1;
                seq_pins.clk = 1'b1;
                seq_pins.dio = (ph == 3'd0);
                len = tmg.start_half_ticks;
            end
            CMD_STOP: begin
                seq_pins.oe = 1'b1;
                seq_pins.clk = (ph != 3'd0);
                seq_pins.dio = (ph == 3'd2);
                len = (ph == 3'd0) ? tmg.low_ticks : tmg.high_ticks;
            end
            CMD_DRIVE: begin
                seq_pins.oe = 1'b1;
                seq_pins.clk = (ph != 3'd0);
                if (ph == 3'd0 && seq_bits != 6'd0) seq_pins.dio = seq_word[seq_bits - 6'd1];
                len = (ph == 3'd0) ? tmg.low_ticks : tmg.high_ticks;
            end
            CMD_SAMPLE: begin
                seq_pins.clk = (ph != 3'd0);
                len = (ph == 3'd0) ? tmg.sample_low_ticks : tmg.sample_high_ticks;
            end
            default: begin
                seq_pins.clk = (ph != 3'd0);
                len = (ph == 3'd0) ? tmg.low_ticks : tmg.high_ticks;
            end
        endcase
        seq_ticks = (len == 8'd0) ? 8'd1 : len;
    endfunction

    function automatic void wake_done();
        if (seq_stop) enter_phase(CMD_STOP, 3'd0);
        else seq_cmd = CMD_IDLE;
    endfunction

    function automatic logic end_phase(logic din);
        logic done;
        done = 1'b0;
        case (seq_cmd)
            CMD_START: begin
                if (seq_phase == 3'd0) enter_phase(CMD_START, 3'd1);
                else seq_cmd = CMD_IDLE;
            end
            CMD_STOP: begin
                if (seq_phase < 3'd2) enter_phase(CMD_STOP, seq_phase + 3'd1);
                else seq_cmd = CMD_IDLE;
            end
            CMD_DRIVE: begin
                if (seq_phase == 3'd0) begin
                    enter_phase(CMD_DRIVE, 3'd1);
                end else begin
                    if (seq_bits != 6'd0) seq_bits = seq_bits - 6'd1;
                    if (seq_bits == 6'd0) seq_cmd = CMD_IDLE;
                    else enter_phase(CMD_DRIVE, 3'd0);
                end
            end
            CMD_SAMPLE: begin
                if (seq_phase == 3'd0) begin
                    enter_phase(CMD_SAMPLE, 3'd1);
                end else begin
                    seq_word = {seq_word[30:0], din};
                    if (seq_bits != 6'd0) seq_bits = seq_bits - 6'd1;
                    if (seq_bits == 6'd0) begin
                        seq_cmd = CMD_IDLE;
                        done = 1'b1;
                    end else begin
                        enter_phase(CMD_SAMPLE, 3'd0);
                    end
                end
            end
            CMD_WAKE: begin
                if (seq_phase == 3'd0) begin
                    enter_phase(CMD_WAKE, 3'd1);
                end else begin
                    if (seq_pulses != 8'd0) seq_pulses = seq_pulses - 8'd1;
                    if (seq_pulses == 8'd0) wake_done();
                    else enter_phase(CMD_WAKE, 3'd0);
                end
            end
            default: seq_cmd = CMD_IDLE;
        endcase
        return done;
    endfunction

    function automatic t_result predict_tick(t_tick tk);
        t_result    r;
        t_pins      shown;
        logic [5:0] count;
        logic       valid;
        count = (tk.count > WORD_BITS) ? WORD_BITS : tk.count;
        valid = 1'b0;
        if (seq_cmd == CMD_IDLE) begin
            case (tk.opcode)
                CMD_START: enter_phase(CMD_START, 3'd0);
                CMD_STOP: enter_phase(CMD_STOP, 3'd0);
                CMD_DRIVE: begin
                    if (count != 6'd0) begin
                        seq_word = tk.send;
                        seq_bits = count;
                        enter_phase(CMD_DRIVE, 3'd0);
                    end
                end
                CMD_SAMPLE: begin
                    seq_pins.oe = 1'b0;
                    seq_pins.dio = 1'b1;
                    seq_word = '0;
                    if (count == 6'd0) begin
                        valid = 1'b1;
                    end else begin
                        seq_bits = count;
                        enter_phase(CMD_SAMPLE, 3'd0);
                    end
                end
                CMD_WAKE: begin
                    seq_pins = '{clk: 1'b1, dio: 1'b1, oe: 1'b1};
                    seq_stop = tk.stop_after;
                    seq_pulses = tmg.wakeup_clocks;
                    if (seq_pulses == 8'd0) wake_done();
                    else enter_phase(CMD_WAKE, 3'd0);
                end
                default: ;
            endcase
        end
        shown = seq_pins;
        if (seq_cmd != CMD_IDLE) begin
            if (seq_ticks != 8'd0) seq_ticks = seq_ticks - 8'd1;
            if (seq_ticks == 8'd0) valid = end_phase(tk.din) | valid;
        end
        r.swclk = shown.clk;
        r.swdio_out = shown.dio;
        r.swdio_oe = shown.oe;
        r.busy_res = (seq_cmd != CMD_IDLE);
        r.read_valid = valid;
        r.read_bits = valid ? seq_word : '0;
        return r;
    endfunction

    function automatic void reset_model();
        tmg = '{RST_LOW_TICKS, RST_HIGH_TICKS, RST_SAMPLE_LOW_TICKS, RST_SAMPLE_HIGH_TICKS,
                RST_START_HALF_TICKS, RST_WAKEUP_CLOCKS};
        seq_cmd = CMD_IDLE;
        seq_phase = '0;
        seq_ticks = '0;
        seq_bits = '0;
        seq_word = '0;
        seq_pulses = '0;
        seq_stop = 1'b0;
        seq_pins = '{clk: 1'b1, dio: 1'b1, oe: 1'b1};
    endfunction

    function automatic t_tick random_tick(int cap);
        t_tick tk;
        int    r;
        tk.send = $urandom();
        tk.stop_after = 1'($urandom_range(0, 1));
        tk.din = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (cap <= 2) tk.count = 6'($urandom_range(0, cap));
        else if (r == 0) tk.count = 6'd0;
        else if (r == 1) tk.count = 6'($urandom_range(33, 63));
        else if (r < 4) tk.count = 6'($urandom_range(9, 32));
        else tk.count = 6'($urandom_range(1, 8));
        if (seq_cmd == CMD_IDLE) begin
            r = $urandom_range(0, 19);
            if (r < 8) tk.opcode = 3'($urandom_range(CMD_START, CMD_WAKE));
            else if (r == 8) tk.opcode = 3'($urandom_range(0, 7));
            else tk.opcode = CMD_IDLE;
        end else begin
            tk.opcode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : CMD_IDLE;
        end
        return tk;
    endfunction

    function automatic t_tick plain_tick();
        t_tick tk;
        tk = '0;
        tk.opcode = CMD_IDLE;
        tk.din = 1'($urandom_range(0, 1));
        return tk;
    endfunction

    task automatic send_tick(input t_tick tk, input logic typed, input t_result want);
        t_result model_res;
        push <= 1'b1;
        i_opcode <= tk.opcode;
        i_send_bits <= tk.send;
        i_bit_count <= tk.count;
        i_stop_after <= tk.stop_after;
        i_swdio_in <= tk.din;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        model_res = predict_tick(tk);
        tick_results_due.push_back(typed ? want : model_res);
    endtask

    task automatic hold_push(input int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (!quiet_end && $urandom_range(0, 7) == 0) hold_push($urandom_range(1, 16));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_LOW_TICKS: tmg.low_ticks = val;
            REG_HIGH_TICKS: tmg.high_ticks = val;
            REG_SAMPLE_LOW_TICKS: tmg.sample_low_ticks = val;
            REG_SAMPLE_HIGH_TICKS: tmg.sample_high_ticks = val;
            REG_START_HALF_TICKS: tmg.start_half_ticks = val;
            REG_WAKEUP_CLOCKS: tmg.wakeup_clocks = val;
            default: ;
        endcase
    endtask

    task automatic write_timing(input t_cfg c);
        write_reg(REG_LOW_TICKS, c.low_ticks);
        write_reg(REG_HIGH_TICKS, c.high_ticks);
        write_reg(REG_SAMPLE_LOW_TICKS, c.sample_low_ticks);
        write_reg(REG_SAMPLE_HIGH_TICKS, c.sample_high_ticks);
        write_reg(REG_START_HALF_TICKS, c.start_half_ticks);
        write_reg(REG_WAKEUP_CLOCKS, c.wakeup_clocks);
        i_cfg_valid <= 1'b0;
    endtask

    // Run the sequencer back to idle, then wait for every request to come back.
    task automatic settle();
        while (seq_cmd != CMD_IDLE) send_tick(plain_tick(), 1'b0, NO_CHECK);
        push <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_cfg c, input int n_ticks, input int cap,
                             input bit pause_midway);
        write_timing(c);
        for (int k = 0; k < n_ticks; k++) begin
            if (pause_midway && k == n_ticks / 2) begin
                push <= 1'b0;
                while (tick_results_due.size() != 0) @(posedge i_clk);
            end else begin
                maybe_gap();
            end
            send_tick(random_tick(cap), 1'b0, NO_CHECK);
        end
        settle();
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_swclk, o_swdio_out, o_swdio_oe, o_busy_res, o_read_valid, o_read_bits};
            if (tick_results_due.size() == 0) begin
                faults++;
                if (faults <= 10) $display("unexpected result: %p", got);
            end else begin
                want = tick_results_due.pop_front();
                if (got !== want) begin
                    faults++;
                    if (faults <= 10)
                        $display("mismatch: want clk=%b dio=%b oe=%b busy=%b valid=%b bits=%h, got clk=%b dio=%b oe=%b busy=%b valid=%b bits=%h",
                                 want.swclk, want.swdio_out, want.swdio_oe, want.busy_res,
                                 want.read_valid, want.read_bits, got.swclk, got.swdio_out,
                                 got.swdio_oe, got.busy_res, got.read_valid, got.read_bits);
                end
            end
        end
        if (quiet_end) begin
            pop <= 1'b1;
        end else if (pop_rest > 0) begin
            pop_rest--;
            pop <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            pop_rest = $urandom_range(0, 15);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        t_tick tk;
        reset_model();
        script = '{
            '{CMD_IDLE,   32'h00000000, 6'd0,  1'b0, 1'b0, 1'b1, IDLE_PINS},
            '{OP_RSVD_6,  32'hFFFFFFFF, 6'd63, 1'b1, 1'b0, 1'b1, IDLE_PINS},
            '{OP_RSVD_7,  32'h00000000, 6'd0,  1'b0, 1'b0, 1'b1, IDLE_PINS},
            '{CMD_DRIVE,  32'hFFFFFFFF, 6'd0,  1'b0, 1'b0, 1'b1, IDLE_PINS},
            '{CMD_SAMPLE, 32'h00000000, 6'd0,  1'b0, 1'b0, 1'b1, EMPTY_READ},
            '{CMD_START,  32'h00000000, 6'd0,  1'b0, 1'b1, 1'b0, NO_CHECK},
            '{CMD_STOP,   32'h00000000, 6'd0,  1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_STOP,   32'h00000000, 6'd0,  1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_DRIVE,  32'hFFFFFFFF, 6'd32, 1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_DRIVE,  32'h00000000, 6'd32, 1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_DRIVE,  32'h80000001, 6'd63, 1'b1, 1'b0, 1'b0, NO_CHECK},
            '{CMD_DRIVE,  32'hFFFFFFF5, 6'd3,  1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_SAMPLE, 32'h00000000, 6'd32, 1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_SAMPLE, 32'hFFFFFFFF, 6'd45, 1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_SAMPLE, 32'h00000000, 6'd1,  1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_WAKE,   32'h00000000, 6'd0,  1'b0, 1'b0, 1'b0, NO_CHECK},
            '{CMD_WAKE,   32'h00000000, 6'd0,  1'b1, 1'b0, 1'b0, NO_CHECK},
            '{CMD_DRIVE,  32'hA5A5A5A5, 6'd1,  1'b0, 1'b1, 1'b0, NO_CHECK},
            '{CMD_SAMPLE, 32'h00000000, 6'd8,  1'b0, 1'b0, 1'b0, NO_CHECK},
            '{OP_RSVD_7,  32'h5A5A5A5A, 6'd17, 1'b1, 1'b0, 1'b0, NO_CHECK}
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero timing values act as one tick; zero wakeup clocks skip the pulses.
        write_timing('{8'd0, 8'd1, 8'd2, 8'd0, 8'd0, 8'd0});
        for (int k = 0; k < SCRIPT_LEN; k++) begin
            tk.opcode = script[k].opcode;
            tk.send = script[k].send;
            tk.count = script[k].count;
            tk.stop_after = script[k].stop_after;
            tk.din = 1'($urandom_range(0, 1));
            maybe_gap();
            send_tick(tk, script[k].typed, script[k].want);
            if (!script[k].hold) begin
                while (seq_cmd != CMD_IDLE) begin
                    maybe_gap();
                    send_tick(plain_tick(), 1'b0, NO_CHECK);
                end
            end
        end
        settle();

        run_phase('{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd255}, 300, 63, 1'b0);
        run_phase('{8'd4, 8'd2, 8'd16, 8'd16, 8'd8, 8'd5}, 400, 63, 1'b1);
        run_phase('{8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 6)), 8'($urandom_range(1, 8))}, 400, 63, 1'b0);
        run_phase('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1}, 300, 2, 1'b0);
        quiet_end = 1'b1;
        run_phase('{8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                    8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                    8'($urandom_range(1, 4)), 8'($urandom_range(1, 4))}, 350, 63, 1'b0);

        repeat (10) @(posedge i_clk);
        if (faults == 0 && tick_results_due.size() == 0) begin
            $display("** two_wire_debug_master_phy_unit: PASSED **");
        end else begin
            $display("** two_wire_debug_master_phy_unit: FAILED **");
        end
        $finish;
    end

endmodule
